### rtl/ukrt_pkg.sv
// Shared constants and types for the unique key record table.
// No dependencies.
package ukrt_pkg;
	localparam int Capacity    = 64;
	localparam int KeyBits     = 16;
	localparam int PayloadBits = 32;
	localparam int AddrBits    = $clog2(Capacity);
	localparam int CountBits   = $clog2(Capacity + 1);
	localparam int RecBits     = KeyBits + PayloadBits;

	typedef enum logic [2:0] {
		ACT_ADD = 3'd0, ACT_REMOVE_KEY = 3'd1, ACT_INSERT_AT = 3'd2,
		ACT_REMOVE_AT = 3'd3, ACT_LOOKUP = 3'd4, ACT_READ = 3'd5,
		ACT_CLEAR = 3'd6, ACT_SORT = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_NOT_FOUND = 3'd1, ST_DUPLICATE = 3'd2,
		ST_FULL = 3'd3, ST_BAD_POS = 3'd4
	} status_t;
endpackage

### rtl/ukrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ukrt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/unique_key_record_table_core.sv
// Unique key record table: ordered table of key/payload records in one RAM.
// Depends on ukrt_pkg and ukrt_ram.
// Sort runs bubble passes. One request at a time: busy is high from request to the
// result cycle; the result strobe lasts one cycle and the receiver cannot stall.
// Reset empties the table at once; the RAM is not cleared.
module unique_key_record_table_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                action,
	input  logic [ukrt_pkg::KeyBits-1:0]     key,
	input  logic [ukrt_pkg::PayloadBits-1:0] payload,
	input  logic [6:0]                position,
	output logic                      done,
	output logic [2:0]                status,
	output logic [6:0]                found_position,
	output logic [6:0]                entry_count,
	output logic [ukrt_pkg::KeyBits-1:0]     entry_key,
	output logic [ukrt_pkg::PayloadBits-1:0] entry_payload
);
	import ukrt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_SHL, S_SHR, S_SHR_END, S_PUT, S_RDPOS, S_RDWAIT,
		S_SORT_START, S_SORT_LOAD, S_SORT_STEP, S_SORT_TAIL, S_DONE
	} state_t;

	state_t state_q;
	action_t act_q;
	logic [KeyBits-1:0]     key_q;
	logic [PayloadBits-1:0] pay_q;
	logic [CountBits-1:0]   pos_q, count_q, idx_q, slot_q, last_q;
	logic                   found_q, swapped_q, ins_pending_q;
	logic [RecBits-1:0]     prev_q;

	logic                 we;
	logic [AddrBits-1:0]  waddr, raddr;
	logic [RecBits-1:0]   wdata, rdata;
	logic [KeyBits-1:0]   rkey;
	logic                 sort_swap;

	ukrt_ram #(.Width(RecBits), .Depth(Capacity)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign rkey = rdata[RecBits-1 -: KeyBits];
	assign busy = (state_q != S_IDLE);
	// During a sort pass prev_q carries the largest record seen so far.
	assign sort_swap = (prev_q[RecBits-1 -: KeyBits] > rkey);

	always_comb begin
		raddr = AddrBits'(idx_q);
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		unique case (state_q)
			S_SHL: begin
				// idx_q walks up; the entry read last cycle moves to idx_q-2.
				we = (idx_q > slot_q);
				waddr = AddrBits'(idx_q - CountBits'(2));
				wdata = rdata;
			end
			S_SHR: begin
				// idx_q walks down; the entry read last cycle moves to idx_q+2.
				we = (idx_q + CountBits'(1) < count_q);
				waddr = AddrBits'(idx_q + CountBits'(2));
				wdata = rdata;
			end
			S_SHR_END: begin
				we = 1'b1;
				waddr = AddrBits'(idx_q + CountBits'(1));
				wdata = rdata;
			end
			S_PUT: begin
				we = 1'b1;
				waddr = AddrBits'(pos_q - CountBits'(1));
				wdata = {key_q, pay_q};
			end
			S_SORT_STEP: begin
				raddr = AddrBits'(idx_q + CountBits'(1));
				we = 1'b1;
				waddr = AddrBits'(idx_q - CountBits'(1));
				wdata = sort_swap ? rdata : prev_q;
			end
			S_SORT_TAIL: begin
				we = 1'b1;
				waddr = AddrBits'(last_q - CountBits'(1));
				wdata = prev_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done <= 1'b0;
			status <= '0;
			found_position <= '0;
			entry_count <= '0;
			entry_key <= '0;
			entry_payload <= '0;
			act_q <= ACT_ADD;
			key_q <= '0;
			pay_q <= '0;
			pos_q <= '0;
			idx_q <= '0;
			slot_q <= '0;
			last_q <= '0;
			found_q <= 1'b0;
			swapped_q <= 1'b0;
			ins_pending_q <= 1'b0;
			prev_q <= '0;
		end else begin
			done <= (state_q == S_DONE);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						act_q <= action_t'(action);
						key_q <= key;
						pay_q <= payload;
						pos_q <= CountBits'(position);
						idx_q <= '0;
						found_q <= 1'b0;
						ins_pending_q <= 1'b0;
						status <= ST_OK;
						found_position <= '0;
						entry_key <= '0;
						entry_payload <= '0;
						unique case (action_t'(action))
							ACT_REMOVE_AT, ACT_READ: state_q <= S_RDPOS;
							ACT_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							ACT_SORT: begin
								last_q <= count_q;
								swapped_q <= 1'b0;
								state_q <= (count_q > CountBits'(1)) ? S_SORT_START : S_DONE;
							end
							default: state_q <= (count_q == '0) ? S_DECIDE : S_SCAN;
						endcase
					end
				end
				// Reads are issued at idx_q; rdata holds the entry at idx_q-1, read the cycle before.
				S_SCAN: begin
					if (idx_q != '0 && !found_q && rkey == key_q) begin
						found_q <= 1'b1;
						slot_q <= idx_q;
						prev_q <= rdata;
						state_q <= S_DECIDE;
					end else if (idx_q == count_q) begin
						state_q <= S_DECIDE;
					end else begin
						idx_q <= idx_q + CountBits'(1);
					end
				end
				S_DECIDE: begin
					unique case (act_q)
						ACT_ADD: begin
							if (found_q) begin
								status <= ST_DUPLICATE;
								found_position <= 7'(slot_q);
								entry_key <= prev_q[RecBits-1 -: KeyBits];
								entry_payload <= prev_q[PayloadBits-1:0];
								state_q <= S_DONE;
							end else if (count_q >= CountBits'(Capacity)) begin
								status <= ST_FULL;
								state_q <= S_DONE;
							end else begin
								pos_q <= count_q + CountBits'(1);
								found_position <= 7'(count_q + CountBits'(1));
								entry_key <= key_q;
								entry_payload <= pay_q;
								state_q <= S_PUT;
							end
						end
						ACT_REMOVE_KEY, ACT_LOOKUP: begin
							if (!found_q) begin
								status <= ST_NOT_FOUND;
								state_q <= S_DONE;
							end else begin
								found_position <= 7'(slot_q);
								entry_key <= prev_q[RecBits-1 -: KeyBits];
								entry_payload <= prev_q[PayloadBits-1:0];
								if (act_q == ACT_REMOVE_KEY) begin
									idx_q <= slot_q;
									state_q <= S_SHL;
								end else begin
									state_q <= S_DONE;
								end
							end
						end
						default: begin
							// Insert at position.
							if (pos_q == '0 ||
							    pos_q > (found_q ? count_q : count_q + CountBits'(1))) begin
								status <= ST_BAD_POS;
								state_q <= S_DONE;
							end else if (!found_q && count_q >= CountBits'(Capacity)) begin
								status <= ST_FULL;
								state_q <= S_DONE;
							end else begin
								found_position <= 7'(pos_q);
								entry_key <= key_q;
								entry_payload <= pay_q;
								ins_pending_q <= 1'b1;
								if (found_q) begin
									idx_q <= slot_q;
									state_q <= S_SHL;
								end else begin
									idx_q <= count_q - CountBits'(1);
									state_q <= (count_q >= pos_q) ? S_SHR : S_PUT;
								end
							end
						end
					endcase
				end
				// Shift left: read idx, write idx-1 in the next cycle.
				S_SHL: begin
					if (idx_q == count_q) begin
						count_q <= count_q - CountBits'(1);
						if (ins_pending_q) begin
							idx_q <= count_q - CountBits'(2);
							state_q <= (count_q - CountBits'(1) >= pos_q) ? S_SHR : S_PUT;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						idx_q <= idx_q + CountBits'(1);
					end
				end
				// Shift right: read idx, write idx+1 in the next cycle, walking down to pos-1.
				S_SHR: begin
					if (idx_q + CountBits'(1) == pos_q) begin
						state_q <= S_SHR_END;
					end else begin
						idx_q <= idx_q - CountBits'(1);
					end
				end
				S_SHR_END: begin
					state_q <= S_PUT;
				end
				S_PUT: begin
					count_q <= count_q + CountBits'(1);
					state_q <= S_DONE;
				end
				S_RDPOS: begin
					if (pos_q == '0 || pos_q > count_q) begin
						status <= ST_BAD_POS;
						state_q <= S_DONE;
					end else begin
						idx_q <= pos_q - CountBits'(1);
						state_q <= S_RDWAIT;
					end
				end
				S_RDWAIT: begin
					if (idx_q == pos_q) begin
						found_position <= 7'(pos_q);
						entry_key <= rkey;
						entry_payload <= rdata[PayloadBits-1:0];
						if (act_q == ACT_REMOVE_AT) begin
							idx_q <= pos_q;
							slot_q <= pos_q;
							ins_pending_q <= 1'b0;
							state_q <= S_SHL;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						idx_q <= pos_q;
					end
				end
				// A pass reads entry 0, then per cycle compares the carried record with
				// the next entry and writes the smaller one back one slot lower.
				S_SORT_START: begin
					idx_q <= CountBits'(1);
					state_q <= S_SORT_LOAD;
				end
				S_SORT_LOAD: begin
					prev_q <= rdata;
					state_q <= S_SORT_STEP;
				end
				S_SORT_STEP: begin
					if (sort_swap) begin
						swapped_q <= 1'b1;
					end else begin
						prev_q <= rdata;
					end
					if (idx_q + CountBits'(1) == last_q) begin
						state_q <= S_SORT_TAIL;
					end else begin
						idx_q <= idx_q + CountBits'(1);
					end
				end
				S_SORT_TAIL: begin
					last_q <= last_q - CountBits'(1);
					idx_q <= '0;
					swapped_q <= 1'b0;
					state_q <= (swapped_q && last_q > CountBits'(2)) ? S_SORT_START : S_DONE;
				end
				default: begin
					entry_count <= 7'(count_q);
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

### tb/sv/unique_key_record_table_core_tb.sv
`timescale 1ns / 100ps
// Testbench for the unique key record table: drives table requests, predicts
// each result with a behavioral table and checks every done strobe. Depends on ukrt_pkg.
module unique_key_record_table_core_tb;
	import ukrt_pkg::*;

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  fpos;
		logic [6:0]  count;
		logic [15:0] ekey;
		logic [31:0] epay;
	} table_result_t;

	class table_scoreboard;
		logic [15:0]   keys [Capacity];
		logic [31:0]   pays [Capacity];
		int            used;
		table_result_t pending [$];
		int            mismatches;

		function int find_slot(logic [15:0] k);
			for (int i = 0; i < used; i++)
				if (keys[i] == k)
					return i + 1;
			return 0;
		endfunction

		function void drop_slot(int slot);
			for (int i = slot; i < used; i++) begin
				keys[i-1] = keys[i];
				pays[i-1] = pays[i];
			end
			used--;
		endfunction

		function void place_slot(int slot, logic [15:0] k, logic [31:0] p);
			for (int i = used; i >= slot; i--) begin
				keys[i] = keys[i-1];
				pays[i] = pays[i-1];
			end
			keys[slot-1] = k;
			pays[slot-1] = p;
			used++;
		endfunction

		function void note_request(action_t act, logic [15:0] k, logic [31:0] p,
				logic [6:0] pos);
			table_result_t r;
			int slot, cnt, last;
			logic [15:0] tk;
			logic [31:0] tp;
			bit swapped;
			r = '0;
			r.status = ST_OK;
			case (act)
				ACT_ADD: begin
					slot = find_slot(k);
					if (slot != 0) begin
						r.status = ST_DUPLICATE; r.fpos = 7'(slot);
						r.ekey = keys[slot-1]; r.epay = pays[slot-1];
					end else if (used >= Capacity)
						r.status = ST_FULL;
					else begin
						place_slot(used + 1, k, p);
						r.fpos = 7'(used); r.ekey = k; r.epay = p;
					end
				end
				ACT_REMOVE_KEY, ACT_LOOKUP: begin
					slot = find_slot(k);
					if (slot == 0)
						r.status = ST_NOT_FOUND;
					else begin
						r.fpos = 7'(slot); r.ekey = keys[slot-1]; r.epay = pays[slot-1];
						if (act == ACT_REMOVE_KEY)
							drop_slot(slot);
					end
				end
				ACT_INSERT_AT: begin
					slot = find_slot(k);
					cnt = (slot != 0) ? used - 1 : used;
					if (pos == 0 || pos > cnt + 1)
						r.status = ST_BAD_POS;
					else if (slot == 0 && used >= Capacity)
						r.status = ST_FULL;
					else begin
						if (slot != 0)
							drop_slot(slot);
						place_slot(pos, k, p);
						r.fpos = pos; r.ekey = k; r.epay = p;
					end
				end
				ACT_REMOVE_AT, ACT_READ: begin
					if (pos == 0 || pos > used)
						r.status = ST_BAD_POS;
					else begin
						r.fpos = pos; r.ekey = keys[pos-1]; r.epay = pays[pos-1];
						if (act == ACT_REMOVE_AT)
							drop_slot(pos);
					end
				end
				ACT_CLEAR: used = 0;
				default: begin
					last = used;
					swapped = 1;
					while (swapped && last > 1) begin
						swapped = 0;
						for (int i = 0; i + 1 < last; i++)
							if (keys[i] > keys[i+1]) begin
								tk = keys[i]; tp = pays[i];
								keys[i] = keys[i+1]; pays[i] = pays[i+1];
								keys[i+1] = tk; pays[i+1] = tp;
								swapped = 1;
							end
						last--;
					end
				end
			endcase
			r.count = 7'(used);
			pending.push_back(r);
		endfunction

		function void check_result(table_result_t got);
			table_result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic [2:0]  action = '0;
	logic [15:0] key = '0;
	logic [31:0] payload = '0;
	logic [6:0]  position = '0;
	logic        busy, done;
	logic [2:0]  status;
	logic [6:0]  found_position, entry_count;
	logic [15:0] entry_key;
	logic [31:0] entry_payload;

	table_scoreboard table_sb = new();
	int idle_pct = 14;
	int stall_cycles = 0;
	logic [15:0] key_pool [16];

	always #6 clk = ~clk;

	unique_key_record_table_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .key(key), .payload(payload), .position(position),
		.done(done), .status(status), .found_position(found_position),
		.entry_count(entry_count), .entry_key(entry_key), .entry_payload(entry_payload)
	);

	always @(posedge clk) begin
		if (done)
			table_sb.check_result({status, found_position, entry_count, entry_key,
				entry_payload});
	end

	// The watchdog restarts whenever a request or a result is taken.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > 20000) begin
			$display("Verification failed");
			$finish;
		end
	end

	// start stays high between back-to-back requests; idling drops it.
	task automatic send_request(action_t act, logic [15:0] k, logic [31:0] p,
			logic [6:0] pos);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		action <= act;
		key <= k;
		payload <= p;
		position <= pos;
		do
			@(posedge clk);
		while (busy);
		table_sb.note_request(act, k, p, pos);
	endtask

	task automatic wait_drained();
		start <= 0;
		while (table_sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [6:0] pick_position();
		int u;
		u = $urandom_range(99);
		if (u < 5)
			return 7'd0;
		if (u < 12)
			return 7'($urandom_range(64, 127));
		if (u < 20)
			return 7'(table_sb.used + 1);
		return 7'($urandom_range(1, table_sb.used + 1));
	endfunction

	task automatic random_request();
		action_t act;
		logic [15:0] k;
		int u;
		u = $urandom_range(99);
		if (u < 30) act = ACT_ADD;
		else if (u < 42) act = ACT_REMOVE_KEY;
		else if (u < 57) act = ACT_INSERT_AT;
		else if (u < 67) act = ACT_REMOVE_AT;
		else if (u < 80) act = ACT_LOOKUP;
		else if (u < 95) act = ACT_READ;
		else if (u < 97) act = ACT_CLEAR;
		else act = ACT_SORT;
		k = ($urandom_range(99) < 60) ? key_pool[$urandom_range(15)] : 16'($urandom);
		send_request(act, k, $urandom, pick_position());
	endtask

	initial begin
		foreach (key_pool[i])
			key_pool[i] = 16'($urandom);
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty table cases, field extremes, duplicates and reinsertion.
		send_request(ACT_READ, 16'h0, 32'h0, 7'd1);
		send_request(ACT_REMOVE_AT, 16'h0, 32'h0, 7'd0);
		send_request(ACT_LOOKUP, 16'hffff, 32'h0, 7'd0);
		send_request(ACT_REMOVE_KEY, 16'h1234, 32'h0, 7'd0);
		send_request(ACT_SORT, 16'h0, 32'h0, 7'd0);
		send_request(ACT_INSERT_AT, 16'h5, 32'h1, 7'd0);
		send_request(ACT_INSERT_AT, 16'h5, 32'h1, 7'd2);
		send_request(ACT_ADD, 16'hffff, 32'hffffffff, 7'd0);
		send_request(ACT_ADD, 16'h0, 32'h0, 7'd0);
		send_request(ACT_ADD, 16'hffff, 32'h12345678, 7'd0);
		send_request(ACT_INSERT_AT, 16'h8000, 32'haaaa5555, 7'd1);
		send_request(ACT_INSERT_AT, 16'hffff, 32'h5555aaaa, 7'd1);
		send_request(ACT_INSERT_AT, 16'h0, 32'h1, 7'd4);
		send_request(ACT_INSERT_AT, 16'h0, 32'h2, 7'd3);
		send_request(ACT_LOOKUP, 16'h8000, 32'h0, 7'd0);
		send_request(ACT_READ, 16'h0, 32'h0, 7'd127);
		send_request(ACT_READ, 16'h0, 32'h0, 7'd3);
		send_request(ACT_SORT, 16'h0, 32'h0, 7'd0);
		send_request(ACT_REMOVE_AT, 16'h0, 32'h0, 7'd2);
		send_request(ACT_REMOVE_KEY, 16'hffff, 32'h0, 7'd0);
		send_request(ACT_CLEAR, 16'h0, 32'h0, 7'd0);
		// Fill to capacity, then probe the full table.
		for (int i = 0; i < Capacity; i++)
			send_request(ACT_ADD, 16'(i * 977 + 3), $urandom, 7'd0);
		send_request(ACT_ADD, 16'h7777, 32'h1, 7'd0);
		send_request(ACT_INSERT_AT, 16'h7778, 32'h1, 7'd5);
		send_request(ACT_INSERT_AT, 16'd3, 32'h9, 7'd64);
		send_request(ACT_READ, 16'h0, 32'h0, 7'd64);
		send_request(ACT_READ, 16'h0, 32'h0, 7'd65);
		send_request(ACT_SORT, 16'h0, 32'h0, 7'd0);
		wait_drained();

		for (int n = 0; n < 1450; n++) begin
			// A stretch without idling in the middle of the run.
			idle_pct = (n >= 500 && n < 700) ? 0 : 14;
			if (n == 900)
				wait_drained();
			random_request();
		end
		wait_drained();
		repeat (50) @(posedge clk);
		if (table_sb.mismatches == 0 && table_sb.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

### sim.f
rtl/ukrt_pkg.sv
rtl/ukrt_ram.sv
rtl/unique_key_record_table_core.sv
tb/sv/unique_key_record_table_core_tb.sv
